/* sv/pip_pkg.sv */
// shared types and constants of the point-in-polygon tester
// used by the item interface, the sequencer, the edge datapath and the top level
// no dependencies
package pip_pkg;

  // fixed widths of the item fields and of the vertex count
  localparam int COORD_FIELD_W = 16;
  localparam int INDEX_W       = 4;
  localparam int COUNT_W       = 5;

  // defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
  localparam logic [COUNT_W-1:0]    VERTEX_COUNT_RST  = 5'd4;

  // item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } pip_op_t;

  // read request travelling alongside the vertex memory read
  typedef struct packed {
    logic start;  // new test, clear the parity
    logic valid;  // a vertex read was issued
    logic first;  // read of the closing vertex, no edge yet
    logic last;   // read that completes the final edge
  } pip_rd_ctrl_t;

  // walk result from the edge datapath
  typedef struct packed {
    logic valid;
    logic in_poly;
  } pip_done_t;

endpackage

/* sv/pip_item_if.sv */
// input channel of the point-in-polygon tester
// depends on pip_pkg
interface pip_item_if;
  import pip_pkg::*;

  logic                              valid;
  logic                              ready;
  pip_op_t                           opcode;
  logic        [INDEX_W-1:0]         vertex_index;
  logic signed [COORD_FIELD_W-1:0]   coord_x;
  logic signed [COORD_FIELD_W-1:0]   coord_y;

  modport source (output valid, opcode, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, vertex_index, coord_x, coord_y, output ready);
endinterface

/* sv/pip_result_if.sv */
// result channel of the point-in-polygon tester
// no dependencies
interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

/* sv/point_in_polygon_test.sv */
// Crossing-number point-in-polygon tester. A load beat (opcode 0) writes one
// vertex into the vertex memory and gives no result; slots never written
// hold no defined value, so only written vertices may be tested against.
// A test beat (opcode 1) walks the first vertex_count edges (capped at
// MAX_VERTICES) and returns 1 when the point lies inside by odd crossing count.
// For n vertices the walk issues one read of the single-read-port vertex
// memory per cycle (n + 1 reads), followed by a three-stage subtract,
// multiply and compare datapath. One beat is worked on at a time; a finished
// result waits in the output register while the next beat is taken.
// vertex_count sits at byte address 0 of the configuration port.
// depends on pip_pkg, pip_item_if, pip_result_if, pip_ram, pip_edge, pip_seq
module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pip_item_if.sink                        item,
  pip_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pip_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pip_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pip_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = COORD_WIDTH;

  logic [COUNT_W-1:0]   vertex_count;
  logic                 cfg_write;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*CW-1:0]      ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [2*CW-1:0]      ram_rdata;
  pip_rd_ctrl_t         ctrl;
  pip_done_t            done;
  logic signed [CW-1:0] px, py;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_VERTEX_COUNT);
  assign prdata    = (paddr == ADDR_VERTEX_COUNT) ? APB_DATA_W'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (cfg_write) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  // sequencer
  pip_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .vertex_count(vertex_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ctrl        (ctrl),
    .px          (px),
    .py          (py),
    .done        (done)
  );

  // vertex store, x and y side by side
  pip_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // edge datapath
  pip_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .rdata(ram_rdata),
    .px   (px),
    .py   (py),
    .done (done)
  );

endmodule

/* sv/pip_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pip_edge.sv */
// edge datapath: one polygon edge per cycle from the vertex read stream,
// straddle test, exact cross-multiplied crossing compare and parity
// depends on pip_pkg
module pip_edge #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pip_pkg::pip_rd_ctrl_t           ctrl,
  input  logic [2*COORD_WIDTH-1:0]        rdata,
  input  logic signed [COORD_WIDTH-1:0]   px,
  input  logic signed [COORD_WIDTH-1:0]   py,
  output pip_pkg::pip_done_t              done
);
  import pip_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  // read control aligned with the memory data
  pip_rd_ctrl_t ctrl_d;

  // current vertex i and previous vertex j
  logic signed [CW-1:0] xi, yi;
  logic signed [CW-1:0] xj, yj;
  logic                 edge_ok;
  logic                 straddle;

  // stage 1: differences
  logic                 s1_valid, s1_last, s1_straddle;
  logic signed [DW-1:0] s1_dy, s1_dxp, s1_dxe, s1_dyp;

  // stage 2: products
  logic                 s2_valid, s2_last, s2_straddle, s2_dneg;
  logic signed [PW-1:0] s2_lhs, s2_rhs;

  // stage 3: compare and parity
  logic left;
  logic toggle;
  logic parity;

  assign xi = $signed(rdata[2*CW-1:CW]);
  assign yi = $signed(rdata[CW-1:0]);
  assign edge_ok = ctrl_d.valid && !ctrl_d.first;
  assign straddle = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_d   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= '0;
      parity   <= 1'b0;
    end else begin
      ctrl_d   <= ctrl;
      s1_valid <= edge_ok;
      s2_valid <= s1_valid;
      done.valid   <= s2_valid && s2_last;
      done.in_poly <= parity ^ toggle;
      if (ctrl.start) begin
        parity <= 1'b0;
      end else begin
        parity <= parity ^ toggle;
      end
    end
  end

  // previous vertex and stage payloads
  always_ff @(posedge clk) begin
    if (ctrl_d.valid) begin
      xj <= xi;
      yj <= yi;
    end
    s1_last     <= ctrl_d.last;
    s1_straddle <= straddle;
    s1_dy       <= DW'(yj) - DW'(yi);
    s1_dxp      <= DW'(px) - DW'(xi);
    s1_dxe      <= DW'(xj) - DW'(xi);
    s1_dyp      <= DW'(py) - DW'(yi);
    s2_last     <= s1_last;
    s2_straddle <= s1_straddle;
    s2_dneg     <= s1_dy[DW-1];
    s2_lhs      <= PW'(s1_dxp) * PW'(s1_dy);
    s2_rhs      <= PW'(s1_dxe) * PW'(s1_dyp);
  end

  // point left of the crossing, sense flipped for a falling edge
  assign left   = s2_dneg ? (s2_lhs > s2_rhs) : (s2_lhs < s2_rhs);
  assign toggle = s2_valid && s2_straddle && left;

endmodule

/* sv/pip_seq.sv */
// sequencer: item handshake, vertex loads, edge walk over the vertex memory
// and the result register
// depends on pip_pkg, pip_item_if and pip_result_if
module pip_seq #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  pip_item_if.sink                          item,
  pip_result_if.source                      result,
  input  logic [pip_pkg::COUNT_W-1:0]       vertex_count,
  output logic                              ram_we,
  output logic [$clog2(MAX_VERTICES)-1:0]   ram_waddr,
  output logic [2*COORD_WIDTH-1:0]          ram_wdata,
  output logic                              ram_re,
  output logic [$clog2(MAX_VERTICES)-1:0]   ram_raddr,
  output pip_pkg::pip_rd_ctrl_t             ctrl,
  output logic signed [COORD_WIDTH-1:0]     px,
  output logic signed [COORD_WIDTH-1:0]     py,
  input  pip_pkg::pip_done_t                done
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = COORD_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   n_reg;
  logic [COUNT_W-1:0]   k;
  logic                 res;
  logic                 accept;
  logic                 is_test;
  logic                 out_free;
  logic                 push;
  logic [COUNT_W-1:0]   n_sat;
  logic signed [CW-1:0] cx, cy;

  // coordinates wrapped or sign-extended to the working width
  assign cx = CW'(item.coord_x);
  assign cy = CW'(item.coord_y);

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign is_test    = (item.opcode == OP_TEST);
  assign out_free   = !result.valid || result.ready;

  // a finished result enters the output register
  assign push = out_free && (((state == S_DRAIN) && done.valid) || (state == S_DONE));

  // vertex count capped at the store depth
  assign n_sat = (32'(vertex_count) > MAX_VERTICES) ? COUNT_W'(MAX_VERTICES) : vertex_count;

  // load beat writes the vertex store
  assign ram_we    = accept && !is_test && (32'(item.vertex_index) < MAX_VERTICES);
  assign ram_waddr = AW'(item.vertex_index);
  assign ram_wdata = {cx, cy};

  // walk reads the closing vertex first, then vertices 0 to n-1
  assign ram_re    = (state == S_WALK);
  assign ram_raddr = (k == '0) ? AW'(n_reg - COUNT_W'(1)) : AW'(k - COUNT_W'(1));

  assign ctrl.start = accept && is_test;
  assign ctrl.valid = (state == S_WALK);
  assign ctrl.first = (k == '0);
  assign ctrl.last  = (k == n_reg);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      k             <= '0;
      n_reg         <= '0;
      res           <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (push) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && is_test) begin
            px    <= cx;
            py    <= cy;
            n_reg <= n_sat;
            k     <= '0;
            if (n_sat == '0) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          k <= k + COUNT_W'(1);
          if (k == n_reg) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done.valid) begin
            if (out_free) begin
              result.inside_res <= done.in_poly;
              state             <= S_IDLE;
            end else begin
              res   <= done.in_poly;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            result.inside_res <= res;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // walk reads stay inside the vertices in use
  a_walk_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (32'(ram_raddr) < 32'(n_reg)))
    else $error("walk read beyond vertex count");

  // the edge pipeline reports only while the walk drains
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> (state == S_DRAIN))
    else $error("walk result outside drain");

  // walk ends after the final edge read
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && k == n_reg) |=> (state == S_DRAIN))
    else $error("walk overran its edges");

  // a held result is pushed once the output frees
  a_result_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (result.valid && state == S_IDLE))
    else $error("held result not delivered");

endmodule

/* test/point_in_polygon_test_tb.sv */
// self-checking testbench for the point-in-polygon tester: a directed table, then
// random vertex loads and point tests checked against a crossing-number predictor
// depends on pip_pkg, pip_item_if, pip_result_if and the point_in_polygon_test rtl
`timescale 1ns / 100ps

module point_in_polygon_test_tb;
  import pip_pkg::*;

  localparam int MAX_VERTICES    = MAX_VERTICES_DEF;
  localparam int SETTLE_CYCLES   = 32;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 95;

  typedef enum logic {
    ROW_BEAT  = 1'b0,
    ROW_COUNT = 1'b1
  } row_kind_t;

  // one directed step: either an input beat or a vertex_count write
  typedef struct packed {
    row_kind_t                        kind;
    pip_op_t                          op;
    logic [INDEX_W-1:0]               idx;
    logic signed [COORD_FIELD_W-1:0]  x;
    logic signed [COORD_FIELD_W-1:0]  y;
    logic                             typed;
    logic                             want;
    logic [COUNT_W-1:0]               count;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 28;

  // corners of the full coordinate square first, then degenerate counts,
  // a triangle, a load beyond the count and a quad
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_BEAT,  OP_LOAD, 4'd0,  16'h8000, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_LOAD, 4'd1,  16'h7FFF, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_LOAD, 4'd2,  16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_LOAD, 4'd3,  16'h8000, 16'h7FFF, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b1, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h8000, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h8000, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h7FFF, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd15, 16'h0000, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{ROW_COUNT, OP_LOAD, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b0, 5'd0},
    '{ROW_COUNT, OP_LOAD, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd1},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h0000, 16'h0000, 1'b1, 1'b0, 5'd0},
    '{ROW_COUNT, OP_LOAD, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd2},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 5'd0},
    '{ROW_COUNT, OP_LOAD, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd3},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h4000, 16'hC000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'hC000, 16'h4000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_LOAD, 4'd3,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h0100, 16'h0080, 1'b0, 1'b0, 5'd0},
    '{ROW_COUNT, OP_LOAD, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd4},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'hC000, 16'h8AD0, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h4000, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h5555, 16'hAAAA, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_LOAD, 4'd2,  16'hAAAA, 16'h5555, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{ROW_BEAT,  OP_TEST, 4'd0,  16'hAAAA, 16'h5555, 1'b0, 1'b0, 5'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  pip_item_if   item_ch ();
  pip_result_if result_ch ();

  point_in_polygon_test uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state: polygon copy, active count and which slots hold a vertex
  logic signed [COORD_FIELD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_FIELD_W-1:0] poly_y [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]         slot_loaded;
  logic [COUNT_W-1:0]              active_count;

  logic pending_inside [$];
  int   mismatch_count;
  int   cycle_count;
  int   sink_wait;
  bit   quiet;
  logic want_inside;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("point_in_polygon_test: mismatch");
      $finish;
    end
  end

  // crossing-number parity of a point against the active polygon
  function automatic logic crossing_parity(logic signed [COORD_FIELD_W-1:0] px,
                                           logic signed [COORD_FIELD_W-1:0] py);
    int     n;
    int     j;
    longint x, y, xi, yi, xj, yj, d, lhs, rhs;
    logic   parity;
    n = (active_count > MAX_VERTICES) ? MAX_VERTICES : int'(active_count);
    x = px;
    y = py;
    parity = 1'b0;
    for (int i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi <= y && y < yj) || (yj <= y && y < yi)) begin
        // exact compare against the crossing, sense flips with the edge direction
        d   = yj - yi;
        lhs = (x - xi) * d;
        rhs = (xj - xi) * (y - yi);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
          parity = ~parity;
      end
    end
    return parity;
  endfunction

  // random coordinate: mostly small, some extremes, some full range
  function automatic logic signed [COORD_FIELD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_FIELD_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return COORD_FIELD_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // send one input beat and record what it should cause once accepted
  task automatic send_beat(pip_op_t op, logic [INDEX_W-1:0] idx,
                           logic signed [COORD_FIELD_W-1:0] x,
                           logic signed [COORD_FIELD_W-1:0] y,
                           logic typed, logic want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.vertex_index <= idx;
    item_ch.coord_x      <= x;
    item_ch.coord_y      <= y;
    do @(posedge clk); while (!item_ch.ready);
    if (op == OP_LOAD) begin
      poly_x[idx]      = x;
      poly_y[idx]      = y;
      slot_loaded[idx] = 1'b1;
    end else begin
      pending_inside.push_back(typed ? want : crossing_parity(x, y));
    end
  endtask

  // hold the input off until every result is back and the walk has finished
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_inside.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_vertex_count(logic [COUNT_W-1:0] want_count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_VERTEX_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== want_count) begin
      $error("vertex_count: expected %0d, got %0d", want_count, prdata[COUNT_W-1:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write over the configuration port, then read back
  task automatic set_vertex_count(logic [COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VERTEX_COUNT;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_count = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_vertex_count(value);
  endtask

  // random beat: fill any empty active slot first, then loads and tests
  task automatic random_beat();
    int                              n;
    int                              empty_slot;
    int                              pick;
    logic signed [COORD_FIELD_W-1:0] x;
    logic signed [COORD_FIELD_W-1:0] y;
    n = (active_count > MAX_VERTICES) ? MAX_VERTICES : int'(active_count);
    empty_slot = -1;
    for (int s = n - 1; s >= 0; s--)
      if (!slot_loaded[s])
        empty_slot = s;
    if (empty_slot >= 0) begin
      send_beat(OP_LOAD, INDEX_W'(empty_slot), rand_coord(), rand_coord(), 1'b0, 1'b0);
    end else if ($urandom_range(0, 99) < 30) begin
      send_beat(OP_LOAD, INDEX_W'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                1'b0, 1'b0);
    end else begin
      // points on a vertex or at a vertex height hit the edge-end rules
      pick = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
        0: begin
          x = COORD_FIELD_W'($urandom);
          y = COORD_FIELD_W'($urandom);
        end
        1: begin
          x = poly_x[pick];
          y = poly_y[pick];
        end
        2: begin
          x = rand_coord();
          y = poly_y[pick];
        end
        default: begin
          x = rand_coord();
          y = rand_coord();
        end
      endcase
      send_beat(OP_TEST, INDEX_W'($urandom), x, y, 1'b0, 1'b0);
    end
  endtask

  // result sink: random stall before each beat, checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_inside.size() == 0) begin
          $error("inside_res: expected nothing, got %0b", result_ch.inside_res);
          mismatch_count++;
        end else begin
          want_inside = pending_inside.pop_front();
          if (result_ch.inside_res !== want_inside) begin
            $error("inside_res: expected %0b, got %0b", want_inside, result_ch.inside_res);
            mismatch_count++;
          end
        end
        sink_wait = quiet ? 0 : $urandom_range(0, 11);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      result_ch.ready <= (sink_wait == 0);
    end
  end

  // stimulus
  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_ch.valid        = 1'b0;
    item_ch.opcode       = OP_LOAD;
    item_ch.vertex_index = '0;
    item_ch.coord_x      = '0;
    item_ch.coord_y      = '0;
    result_ch.ready      = 1'b0;
    mismatch_count       = 0;
    cycle_count          = 0;
    quiet                = 1'b0;
    slot_loaded          = '0;
    active_count         = VERTEX_COUNT_RST;
    for (int s = 0; s < MAX_VERTICES; s++) begin
      poly_x[s] = '0;
      poly_y[s] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_vertex_count(VERTEX_COUNT_RST);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_COUNT) begin
        settle();
        set_vertex_count(directed_rows[r].count);
      end else begin
        send_beat(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].x,
                  directed_rows[r].y, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // random phases: full store, minimum, saturating counts, then random counts
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: set_vertex_count(5'd16);
        1: set_vertex_count(5'd3);
        2: set_vertex_count(5'd31);
        3: set_vertex_count(5'd17);
        default: set_vertex_count(COUNT_W'($urandom_range(3, 16)));
      endcase
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        if (k % 25 == 0)
          quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0)
          settle();
        random_beat();
      end
    end

    settle();
    if (mismatch_count == 0)
      $display("point_in_polygon_test: match");
    else
      $display("point_in_polygon_test: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/pip_pkg.sv
sv/pip_item_if.sv
sv/pip_result_if.sv
sv/pip_ram.sv
sv/pip_edge.sv
sv/pip_seq.sv
sv/point_in_polygon_test.sv
test/point_in_polygon_test_tb.sv
